// ===== src/sbsp_pkg.sv =====
// Shared types, constants and character helpers for the byte string parser.
`default_nettype none
package sbsp_pkg;

    localparam int MAX_FIELDS_DEF = 16;

    // register indexes on the write port
    localparam logic [1:0] CFG_VALUE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SEPARATOR   = 2'd1;
    localparam logic [1:0] CFG_NUMBER_BASE = 2'd2;

    localparam logic [4:0] VALUE_COUNT_RST = 5'd6;
    localparam logic [7:0] SEPARATOR_RST   = 8'd58;
    localparam logic [5:0] NUMBER_BASE_RST = 6'd16;

    localparam logic [7:0] BYTE_MAX  = 8'd255;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_PLUS = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X_LO = 8'h78;
    localparam logic [7:0] CHAR_X_UP = 8'h58;
    localparam logic [6:0] NOT_DIGIT = 7'd99;

    typedef struct packed {
        logic [4:0] value_count;
        logic [7:0] separator;
        logic [5:0] number_base;
    } cfg_t;

    typedef struct packed {
        logic [4:0] count;
        logic       done_res;
        logic [3:0] byte_index;
        logic       byte_valid;
        logic [7:0] byte_value;
    } res_t;

    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [6:0] d;
        d = NOT_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) d = 7'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h7a) d = 7'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h5a) d = 7'(c - 8'h41 + 8'd10);
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic base_ok(input logic [5:0] b);
        return (b == 6'd0) || (b >= 6'd2 && b <= 6'd36);
    endfunction

endpackage
`default_nettype wire

// ===== src/sbsp_cfg_regs.sv =====
// Configuration registers written through the plain write port.
`default_nettype none
module sbsp_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    output sbsp_pkg::cfg_t     cfg
);

    sbsp_pkg::cfg_t cfg_reg;
    sbsp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sbsp_pkg::CFG_VALUE_COUNT: cfg_next.value_count = cfg_data[4:0];
                sbsp_pkg::CFG_SEPARATOR:   cfg_next.separator   = cfg_data;
                sbsp_pkg::CFG_NUMBER_BASE: cfg_next.number_base = cfg_data[5:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value_count <= sbsp_pkg::VALUE_COUNT_RST;
            cfg_reg.separator   <= sbsp_pkg::SEPARATOR_RST;
            cfg_reg.number_base <= sbsp_pkg::NUMBER_BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== src/sbsp_parse_core.sv =====
// Input register, per-string parse state and the one-character step logic.
`default_nettype none
module sbsp_parse_core #(
    parameter int MAX_FIELDS = sbsp_pkg::MAX_FIELDS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sbsp_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_char,
    input  wire logic          in_start,
    input  wire logic          out_free,
    output logic               res_load,
    output sbsp_pkg::res_t     res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGN   = 3'd2,
        PH_ZERO   = 3'd3,
        PH_HEX    = 3'd4,
        PH_DIGITS = 3'd5
    } phase_t;

    logic       in_vld_reg;
    logic [7:0] char_reg;
    logic       start_reg;

    phase_t     phase_reg,  phase_next;
    logic [7:0] value_reg,  value_next;
    logic       large_reg,  large_next;
    logic       neg_reg,    neg_next;
    logic [5:0] base_reg,   base_next;
    logic [4:0] fields_reg, fields_next;

    logic       advance;
    logic       accept;
    logic [4:0] eff_count;
    logic       res_valid;

    assign advance  = in_vld_reg && out_free;
    assign in_ready = !in_vld_reg || out_free;
    assign accept   = in_valid && in_ready;
    assign res_load = advance && res_valid;

    assign eff_count = (32'(cfg.value_count) > MAX_FIELDS) ? 5'(MAX_FIELDS)
                                                           : cfg.value_count;

    always_comb
    begin
        logic [6:0]  dg;
        logic [14:0] acc;
        logic [5:0]  b;
        logic [5:0]  fa_inc;
        logic        last;
        logic        do_first;
        logic        do_acc;
        logic        do_finish;
        logic        do_fail;
        logic        go;

        phase_next  = phase_reg;
        value_next  = value_reg;
        large_next  = large_reg;
        neg_next    = neg_reg;
        base_next   = base_reg;
        fields_next = fields_reg;
        res_valid   = 1'b0;
        res         = '0;
        dg          = sbsp_pkg::digit_of(char_reg);
        acc         = '0;
        b           = '0;
        fa_inc      = '0;
        last        = 1'b0;
        do_first    = 1'b0;
        do_acc      = 1'b0;
        do_finish   = 1'b0;
        do_fail     = 1'b0;
        go          = 1'b1;

        if (start_reg)
        begin
            value_next  = '0;
            large_next  = 1'b0;
            neg_next    = 1'b0;
            base_next   = '0;
            fields_next = '0;
            if (eff_count == 5'd0)
            begin
                phase_next        = PH_IDLE;
                res_valid         = 1'b1;
                res.done_res      = 1'b1;
                go                = 1'b0;
            end
            else
            begin
                phase_next = PH_LEAD;
            end
        end

        if (go)
        begin
            case (phase_next)
                PH_LEAD:
                begin
                    if (!sbsp_pkg::base_ok(cfg.number_base))
                        do_fail = 1'b1;
                    else if (sbsp_pkg::is_space(char_reg))
                        phase_next = PH_LEAD;
                    else if (char_reg == sbsp_pkg::CHAR_PLUS ||
                             char_reg == sbsp_pkg::CHAR_MINUS)
                    begin
                        neg_next   = (char_reg == sbsp_pkg::CHAR_MINUS);
                        phase_next = PH_SIGN;
                    end
                    else
                        do_first = 1'b1;
                end
                PH_SIGN:
                    do_first = 1'b1;
                PH_ZERO:
                begin
                    if (char_reg == sbsp_pkg::CHAR_X_LO || char_reg == sbsp_pkg::CHAR_X_UP)
                    begin
                        base_next  = 6'd16;
                        phase_next = PH_HEX;
                    end
                    else if (dg < 7'(base_next))
                        do_acc = 1'b1;
                    else
                        do_finish = 1'b1;
                end
                PH_HEX:
                begin
                    if (dg < 7'd16)
                        do_acc = 1'b1;
                    else
                        do_fail = 1'b1;
                end
                PH_DIGITS:
                begin
                    if (dg < 7'(base_next))
                        do_acc = 1'b1;
                    else
                        do_finish = 1'b1;
                end
                default:
                    phase_next = PH_IDLE;
            endcase

            if (do_first)
            begin
                b = cfg.number_base;
                if (!sbsp_pkg::base_ok(b))
                    do_fail = 1'b1;
                else if (char_reg == sbsp_pkg::CHAR_ZERO && (b == 6'd0 || b == 6'd16))
                begin
                    base_next  = (b == 6'd0) ? 6'd8 : 6'd16;
                    value_next = '0;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    if (b == 6'd0)
                        b = 6'd10;
                    base_next = b;
                    if (dg < 7'(b))
                        do_acc = 1'b1;
                    else
                        do_fail = 1'b1;
                end
            end

            if (do_acc)
            begin
                acc = 15'(value_next) * 15'(base_next) + 15'(dg);
                if (acc > 15'(sbsp_pkg::BYTE_MAX))
                begin
                    large_next = 1'b1;
                    value_next = sbsp_pkg::BYTE_MAX;
                end
                else
                    value_next = acc[7:0];
                phase_next = PH_DIGITS;
            end

            if (do_finish)
            begin
                fa_inc = 6'(fields_next) + 6'd1;
                last   = fa_inc >= 6'(eff_count);
                if (large_next || (neg_next && value_next != 8'd0))
                    do_fail = 1'b1;
                else if (last ? (char_reg != sbsp_pkg::CHAR_NUL)
                              : (char_reg != cfg.separator))
                    do_fail = 1'b1;
                else
                begin
                    res_valid      = 1'b1;
                    res.byte_valid = 1'b1;
                    res.byte_value = value_next;
                    res.byte_index = fields_next[3:0];
                    res.done_res   = last;
                    res.count      = last ? fa_inc[4:0] : 5'd0;
                    fields_next    = fa_inc[4:0];
                    value_next     = '0;
                    large_next     = 1'b0;
                    neg_next       = 1'b0;
                    base_next      = '0;
                    phase_next     = last ? PH_IDLE : PH_LEAD;
                end
            end

            if (do_fail)
            begin
                phase_next   = PH_IDLE;
                res_valid    = 1'b1;
                res          = '0;
                res.done_res = 1'b1;
                res.count    = fields_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            phase_reg  <= PH_IDLE;
            value_reg  <= '0;
            large_reg  <= 1'b0;
            neg_reg    <= 1'b0;
            base_reg   <= '0;
            fields_reg <= '0;
        end
        else
        begin
            if (accept)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            if (advance)
            begin
                phase_reg  <= phase_next;
                value_reg  <= value_next;
                large_reg  <= large_next;
                neg_reg    <= neg_next;
                base_reg   <= base_next;
                fields_reg <= fields_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= in_char;
            start_reg <= in_start;
        end
    end

    // an idle parser ignores characters until a start beat
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !start_reg && phase_reg == PH_IDLE) |-> !res_load)
        else $error("result from idle parser");

    // a final accepted field reports a count one past its index
    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.byte_valid && res.done_res) |->
        (res.count == 5'(fields_reg + 5'd1) || start_reg))
        else $error("final count mismatch");

    // a held beat keeps its character while the result side is full
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_free) |=> (in_vld_reg && $stable(char_reg)))
        else $error("held beat lost");

    // any result not carrying a field ends the string
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && !res.byte_valid) |=> (phase_reg == PH_IDLE))
        else $error("failure did not end string");

endmodule
`default_nettype wire

// ===== src/sbsp_out_reg.sv =====
// Result register on the master side of the stream.
`default_nettype none
module sbsp_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire sbsp_pkg::res_t res,
    output logic               out_free,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sbsp_pkg::res_t     out_res
);

    logic           vld_reg;
    sbsp_pkg::res_t res_reg;

    assign out_free  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (load)
            vld_reg <= 1'b1;
        else if (out_ready)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule
`default_nettype wire

// ===== src/separated_byte_string_parser_unit.sv =====
// A character beat waits in the input register until the output register can take its result.
// Throughput: one character per cycle while results are taken; a waiting result stalls the
// parse step, so the input register takes at most one more beat and then holds it.
// Reset (rst_n low, asynchronous) empties both registers, sets the parser idle and loads
// value_count 6, separator 58 (colon) and number_base 16.
`default_nettype none
module separated_byte_string_parser_unit #(
    parameter int MAX_FIELDS = sbsp_pkg::MAX_FIELDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    input  wire logic        s_axis_tuser,   // [0] start_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] byte_value, [11:8] byte_index, [16:12] count
    output logic             m_axis_tuser,   // [0] byte_valid
    output logic             m_axis_tlast    // done_res
);

    sbsp_pkg::cfg_t cfg;
    sbsp_pkg::res_t res;
    sbsp_pkg::res_t out_res;
    logic           res_load;
    logic           out_free;

    sbsp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sbsp_parse_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .in_start (s_axis_tuser),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    sbsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.count, out_res.byte_index, out_res.byte_value};
    assign m_axis_tuser = out_res.byte_valid;
    assign m_axis_tlast = out_res.done_res;

endmodule
`default_nettype wire

// ===== verif/separated_byte_string_parser_unit_tb.sv =====
// Self-checking testbench for the separated byte string parser unit.
module separated_byte_string_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int RANDOM_ITEMS    = 1650;
    localparam int RANDOM_SETTINGS = 12;
    localparam int LONG_HOLD       = 100;
    localparam int MAX_REPORTS     = 40;

    // index 3 is not mapped to any register
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGN   = 3'd2,
        PH_ZERO   = 3'd3,
        PH_HEX    = 3'd4,
        PH_DIGITS = 3'd5
    } parse_phase_t;

    typedef enum int {
        BRK_NONE,
        BRK_CHAR,
        BRK_CUT,
        BRK_BIG,
        BRK_NEG,
        BRK_BARE,
        BRK_TERM
    } break_kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } char_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = sbsp_pkg::CFG_VALUE_COUNT;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] character
    logic        s_axis_tuser = 1'b0;    // [0] start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [7:0] byte_value, [11:8] byte_index, [16:12] count
    logic        m_axis_tuser;           // [0] byte_valid
    logic        m_axis_tlast;           // done_res

    separated_byte_string_parser_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Parser model: register copies and per-string state
    // ---------------------------------------------------------------------
    logic [4:0]   fields_cfg;
    logic [7:0]   sep_cfg;
    logic [5:0]   base_cfg;
    parse_phase_t pstate;
    int unsigned  acc;
    bit           acc_over;
    bit           acc_neg;
    int unsigned  radix;
    int unsigned  taken;

    char_beat_t      pending[$];
    sbsp_pkg::res_t  expected_res[$];
    logic [7:0]      text[$];

    int chars_queued = 0;
    int chars_sent = 0;
    int random_chars = 0;
    int settings_used = 0;
    int results_seen = 0;
    int bytes_seen = 0;
    int ends_seen = 0;
    int errors = 0;
    int cycles = 0;

    function automatic int unsigned digit_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return c - 8'h30;
        if (c >= 8'h61 && c <= 8'h7a)
            return c - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h5a)
            return c - 8'h41 + 10;
        return 99;
    endfunction

    function automatic bit blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit radix_legal(input logic [5:0] b);
        return b == 6'd0 || (b >= 6'd2 && b <= 6'd36);
    endfunction

    function automatic int unsigned field_limit();
        return (fields_cfg > sbsp_pkg::MAX_FIELDS_DEF) ? sbsp_pkg::MAX_FIELDS_DEF : fields_cfg;
    endfunction

    function automatic void clear_acc();
        acc = 0;
        acc_over = 1'b0;
        acc_neg = 1'b0;
        radix = 0;
    endfunction

    function automatic void reset_model();
        fields_cfg = sbsp_pkg::VALUE_COUNT_RST;
        sep_cfg = sbsp_pkg::SEPARATOR_RST;
        base_cfg = sbsp_pkg::NUMBER_BASE_RST;
        pstate = PH_IDLE;
        clear_acc();
        taken = 0;
    endfunction

    function automatic bit abort_string(output sbsp_pkg::res_t r);
        pstate = PH_IDLE;
        r = '0;
        r.done_res = 1'b1;
        r.count = 5'(taken);
        return 1'b1;
    endfunction

    function automatic void add_digit(input int unsigned d);
        int unsigned v;
        v = acc * radix + d;
        if (v > 255)
        begin
            acc_over = 1'b1;
            acc = 255;
        end
        else
            acc = v;
        pstate = PH_DIGITS;
    endfunction

    function automatic bit begin_number(input logic [7:0] c, output sbsp_pkg::res_t r);
        int unsigned b;
        int unsigned d;
        b = base_cfg;
        r = '0;
        if (!radix_legal(base_cfg))
            return abort_string(r);
        // leading zero: octal in auto mode, possible 0x prefix ahead
        if (c == sbsp_pkg::CHAR_ZERO && (b == 0 || b == 16))
        begin
            radix = (b == 0) ? 8 : 16;
            acc = 0;
            pstate = PH_ZERO;
            return 1'b0;
        end
        if (b == 0)
            b = 10;
        radix = b;
        d = digit_val(c);
        if (d < b)
        begin
            add_digit(d);
            return 1'b0;
        end
        return abort_string(r);
    endfunction

    function automatic bit close_field(input logic [7:0] c, output sbsp_pkg::res_t r);
        bit          is_last;
        int unsigned idx;
        int unsigned val;
        r = '0;
        if (acc_over || (acc_neg && acc != 0))
            return abort_string(r);
        is_last = (taken + 1 >= field_limit());
        if (is_last ? (c != sbsp_pkg::CHAR_NUL) : (c != sep_cfg))
            return abort_string(r);
        idx = taken;
        val = acc;
        taken = (taken + 1) % 32;
        clear_acc();
        r.byte_valid = 1'b1;
        r.byte_value = 8'(val);
        r.byte_index = 4'(idx);
        if (is_last)
        begin
            pstate = PH_IDLE;
            r.done_res = 1'b1;
            r.count = 5'(taken);
        end
        else
            pstate = PH_LEAD;
        return 1'b1;
    endfunction

    // returns 1 when the character produces a result beat
    function automatic bit parse_char(input logic [7:0] c, input logic first,
                                      output sbsp_pkg::res_t r);
        int unsigned d;
        r = '0;
        if (first)
        begin
            clear_acc();
            taken = 0;
            if (field_limit() == 0)
            begin
                pstate = PH_IDLE;
                r.done_res = 1'b1;
                return 1'b1;
            end
            pstate = PH_LEAD;
        end
        else if (pstate == PH_IDLE)
            return 1'b0;

        case (pstate)
            PH_LEAD:
            begin
                if (!radix_legal(base_cfg))
                    return abort_string(r);
                if (blank(c))
                    return 1'b0;
                if (c == sbsp_pkg::CHAR_PLUS || c == sbsp_pkg::CHAR_MINUS)
                begin
                    acc_neg = (c == sbsp_pkg::CHAR_MINUS);
                    pstate = PH_SIGN;
                    return 1'b0;
                end
                return begin_number(c, r);
            end
            PH_SIGN:
                return begin_number(c, r);
            PH_ZERO:
            begin
                if (c == sbsp_pkg::CHAR_X_LO || c == sbsp_pkg::CHAR_X_UP)
                begin
                    radix = 16;
                    pstate = PH_HEX;
                    return 1'b0;
                end
                d = digit_val(c);
                if (d < radix)
                begin
                    add_digit(d);
                    return 1'b0;
                end
                return close_field(c, r);
            end
            PH_HEX:
            begin
                // a hex digit must follow the prefix
                d = digit_val(c);
                if (d < 16)
                begin
                    add_digit(d);
                    return 1'b0;
                end
                return abort_string(r);
            end
            default:
            begin
                d = digit_val(c);
                if (d < radix)
                begin
                    add_digit(d);
                    return 1'b0;
                end
                return close_field(c, r);
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------------
    // Character driver: bursts with random gaps
    // ---------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        sbsp_pkg::res_t r;
        char_beat_t     nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            s_axis_tuser <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                chars_sent++;
                if (parse_char(s_axis_tdata, s_axis_tuser, r))
                    expected_res.push_back(r);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    nxt = pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.ch;
                    s_axis_tuser <= nxt.first;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor and receiver stall pattern
    // ---------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    int hold_left;
    int mode_left;
    int stall_mode;
    int next_long_hold;
    int pat_step;

    always @(posedge clk or negedge rst_n)
    begin
        sbsp_pkg::res_t want;
        bit             stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
            stall_mode = 0;
            next_long_hold = 100;
            pat_step = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser === 1'b1)
                    bytes_seen++;
                if (m_axis_tlast === 1'b1)
                    ends_seen++;
                if (expected_res.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result beat with none expected: tdata %h tuser %b tlast %b",
                                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    want = expected_res.pop_front();
                    compare_field("byte_value", want.byte_value, m_axis_tdata[7:0]);
                    compare_field("byte_index", 8'(want.byte_index), 8'(m_axis_tdata[11:8]));
                    compare_field("count", 8'(want.count), 8'(m_axis_tdata[16:12]));
                    compare_field("byte_valid", 8'(want.byte_valid), 8'(m_axis_tuser));
                    compare_field("done_res", 8'(want.done_res), 8'(m_axis_tlast));
                    compare_field("tdata padding", 8'h00, 8'(m_axis_tdata[23:17]));
                end
            end

            // long back-pressure so the block fills up and stalls its input
            if (results_seen >= next_long_hold && hold_left == 0)
            begin
                hold_left = LONG_HOLD;
                next_long_hold += 300;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            else
                mode_left--;
            pat_step++;
            if (hold_left > 0)
            begin
                hold_left--;
                stall = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: stall = 1'b0;
                    1: stall = $urandom_range(0, 1);
                    2: stall = (pat_step % 5) < 2;
                    default: stall = ($urandom_range(0, 7) == 0);
                endcase
            end
            m_axis_tready <= !stall;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("separated_byte_string_parser_unit_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            sbsp_pkg::CFG_VALUE_COUNT: fields_cfg = val[4:0];
            sbsp_pkg::CFG_SEPARATOR:   sep_cfg = val;
            sbsp_pkg::CFG_NUMBER_BASE: base_cfg = val[5:0];
            default: ;
        endcase
    endtask

    // upper data bits are don't-care on the narrow registers
    task automatic apply_setting(input int unsigned vc, input int unsigned sep,
                                 input int unsigned base);
        write_reg(sbsp_pkg::CFG_VALUE_COUNT, {3'($urandom), 5'(vc)});
        write_reg(sbsp_pkg::CFG_SEPARATOR, 8'(sep));
        write_reg(sbsp_pkg::CFG_NUMBER_BASE, {2'($urandom), 6'(base)});
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        while (chars_sent != chars_queued || expected_res.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_text(input bit with_start);
        foreach (text[i])
        begin
            pending.push_back('{ch: text[i], first: with_start && i == 0});
            chars_queued++;
        end
        text.delete();
    endtask

    task automatic add_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    task automatic push_digits(input int unsigned v, input int unsigned rb, input bit upper);
        logic [7:0]  digs[$];
        int unsigned d;
        do
        begin
            d = v % rb;
            digs.push_front(d < 10 ? sbsp_pkg::CHAR_ZERO + 8'(d)
                                   : (upper ? 8'h41 : 8'h61) + 8'(d - 10));
            v = v / rb;
        end
        while (v != 0);
        foreach (digs[i])
            text.push_back(digs[i]);
    endtask

    task automatic push_field(input int unsigned v, input int unsigned b, input bit neg,
                              input bit bare_hex);
        int unsigned rb;
        bit          upper;
        upper = $urandom_range(0, 1);
        if ($urandom_range(0, 5) == 0)
            text.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
        if (neg)
            text.push_back(sbsp_pkg::CHAR_MINUS);
        else if (v == 0 && $urandom_range(0, 3) == 0)
            text.push_back(sbsp_pkg::CHAR_MINUS);
        else if ($urandom_range(0, 7) == 0)
            text.push_back(sbsp_pkg::CHAR_PLUS);

        if (bare_hex)
        begin
            text.push_back(sbsp_pkg::CHAR_ZERO);
            text.push_back(upper ? sbsp_pkg::CHAR_X_UP : sbsp_pkg::CHAR_X_LO);
        end
        else
        begin
            rb = b;
            if (b == 0)
            begin
                case ($urandom_range(0, 2))
                    0: rb = 10;
                    1:
                    begin
                        rb = 8;
                        text.push_back(sbsp_pkg::CHAR_ZERO);
                    end
                    default:
                    begin
                        rb = 16;
                        text.push_back(sbsp_pkg::CHAR_ZERO);
                        text.push_back(upper ? sbsp_pkg::CHAR_X_UP : sbsp_pkg::CHAR_X_LO);
                    end
                endcase
            end
            else if (!radix_legal(6'(b)))
                rb = 10;
            else if (b == 16 && $urandom_range(0, 3) == 0)
            begin
                text.push_back(sbsp_pkg::CHAR_ZERO);
                text.push_back(upper ? sbsp_pkg::CHAR_X_UP : sbsp_pkg::CHAR_X_LO);
            end
            else if ($urandom_range(0, 7) == 0)
                text.push_back(sbsp_pkg::CHAR_ZERO);
            push_digits(v, rb, upper);
        end
    endtask

    // one string for the current settings, well formed or with one defect
    task automatic queue_string(input bit broken);
        int unsigned nf;
        int unsigned bad;
        int unsigned v;
        break_kind_t kind;
        nf = field_limit();
        bad = (nf > 0) ? $urandom_range(0, nf - 1) : 0;
        kind = broken ? break_kind_t'($urandom_range(BRK_CHAR, BRK_TERM)) : BRK_NONE;
        if (nf == 0)
            text.push_back(8'($urandom));
        for (int unsigned i = 0; i < nf; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                v = $urandom_range(0, 1) ? 255 : 0;
            else
                v = $urandom_range(0, 255);
            if (i == bad && kind == BRK_BIG)
                v = $urandom_range(256, 3000);
            if (i == bad && kind == BRK_NEG)
                v = $urandom_range(1, 255);
            push_field(v, base_cfg, i == bad && kind == BRK_NEG, i == bad && kind == BRK_BARE);
            if (i == bad && kind == BRK_TERM)
                text.push_back(8'($urandom));
            else
                text.push_back(i + 1 == nf ? sbsp_pkg::CHAR_NUL : sep_cfg);
        end
        if (kind == BRK_CHAR)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
        // truncated string: the next start lands mid-string
        if (kind == BRK_CUT)
            while (text.size() > 1 && $urandom_range(0, 3) != 0)
                void'(text.pop_back());
        random_chars += text.size();
        queue_text(1'b1);
    endtask

    task automatic queue_noise();
        int unsigned n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            pending.push_back('{ch: 8'($urandom), first: $urandom_range(0, 7) == 0});
            chars_queued++;
        end
    endtask

    function automatic int unsigned setting_count(input int s);
        case (s)
            0: return 1;
            1: return 16;
            2: return 31;
            3: return 2;
            default:
                return ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                                   : $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned setting_separator(input int s);
        case (s)
            0: return sbsp_pkg::CHAR_NUL;
            1: return 255;
            2: return 8'h20;
            3: return sbsp_pkg::CHAR_MINUS;
            4: return 8'h2e;
            default:
                return $urandom_range(0, 1) ? sbsp_pkg::SEPARATOR_RST : $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int unsigned setting_base(input int s);
        case (s)
            0: return 0;
            1: return 36;
            2: return 2;
            3: return 10;
            4: return 8;
            5: return 37;
            default:
                case ($urandom_range(0, 7))
                    0, 1, 2: return 16;
                    3, 4:    return 0;
                    5:       return 10;
                    default: return $urandom_range(2, 36);
                endcase
        endcase
    endfunction

    initial
    begin
        int phase_end;
        int roll;

        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset settings: six hex fields split by colons
        pending.push_back('{ch: 8'h41, first: 1'b0});   // idle, ignored
        chars_queued++;
        add_chars("0x7f:");
        queue_text(1'b1);
        add_chars("z");                                 // restart mid-string, no digits
        queue_text(1'b1);
        add_chars("-1:");                               // negative
        queue_text(1'b1);
        add_chars("0x:");                               // bare prefix
        queue_text(1'b1);
        add_chars("100:");                              // above 255
        queue_text(1'b1);
        add_chars("FF:");
        queue_text(1'b1);
        drain();
        // shrink the field count while a string is open
        apply_setting(2, sbsp_pkg::SEPARATOR_RST, sbsp_pkg::NUMBER_BASE_RST);
        add_chars("-0");
        text.push_back(sbsp_pkg::CHAR_NUL);
        queue_text(1'b0);
        drain();
        // NUL acting as separator, auto base
        write_reg(CFG_SPARE, 8'($urandom));
        apply_setting(2, sbsp_pkg::CHAR_NUL, 0);
        add_chars("077");
        text.push_back(sbsp_pkg::CHAR_NUL);
        add_chars("9");
        text.push_back(sbsp_pkg::CHAR_NUL);
        queue_text(1'b1);
        drain();
        apply_setting(0, sbsp_pkg::SEPARATOR_RST, sbsp_pkg::NUMBER_BASE_RST);
        add_chars("11");
        queue_text(1'b1);
        drain();
        apply_setting(sbsp_pkg::VALUE_COUNT_RST, sbsp_pkg::SEPARATOR_RST, 1);
        add_chars("5");
        queue_text(1'b1);

        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            drain();
            apply_setting(setting_count(s), setting_separator(s), setting_base(s));
            phase_end = random_chars + RANDOM_ITEMS / RANDOM_SETTINGS;
            while (random_chars < phase_end)
            begin
                roll = $urandom_range(0, 19);
                if (roll < 15)
                    queue_string(1'b0);
                else if (roll < 19)
                    queue_string(1'b1);
                else
                    queue_noise();
            end
        end
        drain();

        $display("Sent %0d characters over %0d register settings, %0d in random strings.",
                 chars_sent, settings_used, random_chars);
        $display("Checked %0d result beats: %0d bytes accepted, %0d strings ended.",
                 results_seen, bytes_seen, ends_seen);
        if (errors == 0 && expected_res.size() == 0)
            $display("separated_byte_string_parser_unit_tb passed");
        else
            $display("separated_byte_string_parser_unit_tb failed");
        $finish;
    end

endmodule

// ===== separated_byte_string_parser_unit.f =====
src/sbsp_pkg.sv
src/sbsp_cfg_regs.sv
src/sbsp_parse_core.sv
src/sbsp_out_reg.sv
src/separated_byte_string_parser_unit.sv
verif/separated_byte_string_parser_unit_tb.sv
